// ===== rtl/hla_pkg.sv =====
// Shared types, constants and the sine table of the Hough line accumulator.
// Used by every module of the block; depends on nothing.
package hla_pkg;

  // field widths of the request and result items
  localparam int MODE_W  = 2;
  localparam int PIX_W   = 9;
  localparam int PV_W    = 8;
  localparam int THETA_W = 8;
  localparam int RSEL_W  = 11;
  localparam int COUNT_W = 16;

  // configuration register widths and port format
  localparam int OFF_W      = 11;
  localparam int INV_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // rho datapath widths
  localparam int SIN_W     = 15;
  localparam int MAG_W     = 7;
  localparam int DEG_W     = 8;
  localparam int PROD_W    = PIX_W + SIN_W;
  localparam int RHO_SUM_W = PROD_W + 2;
  localparam int SCALED_W  = RHO_SUM_W + INV_W + 1;
  localparam int FRAC_BITS = 22;

  // angle constants: bins span -90 .. +89 degrees
  localparam int THETA_SPAN  = 179;
  localparam int DEG_ZERO    = 90;
  localparam int QUARTER_DEG = 90;

  // default geometry
  localparam int NUM_THETA_DEF = 180;
  localparam int RHO_BINS_DEF  = 2048;
  localparam int IMG_DIM_DEF   = 512;

  // command queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [PV_W-1:0]    EDGE_VALUE = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

  localparam logic [OFF_W-1:0] RHO_OFFSET_RST   = 11'd724;
  localparam logic [INV_W-1:0] RHO_STEP_INV_RST = 13'd256;

  // request modes
  localparam logic [MODE_W-1:0] MODE_VOTE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RHO_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO_STEP_INV = 2'd1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [PIX_W-1:0]   pix_x;
    logic [PIX_W-1:0]   pix_y;
    logic [PV_W-1:0]    pixel_value;
    logic [THETA_W-1:0] theta_sel;
    logic [RSEL_W-1:0]  rho_sel;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic [THETA_W-1:0] bin_theta;
    logic [RSEL_W-1:0]  bin_rho;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_VOTE,
    CMD_READ,
    CMD_CLEAR
  } cmd_op_e;

  // classified command handed from front to back
  typedef struct packed {
    cmd_op_e            op;
    logic [PIX_W-1:0]   pix_x;
    logic [PIX_W-1:0]   pix_y;
    logic [THETA_W-1:0] theta_sel;
    logic [RSEL_W-1:0]  rho_sel;
    logic               rd_hit;
  } cmd_t;

  typedef struct packed {
    logic [OFF_W-1:0] rho_offset;
    logic [INV_W-1:0] rho_step_inv;
  } cfg_t;

  typedef struct packed {
    logic clearing;
  } status_t;

  // sin(0..90 degrees) in Q1.14, rounded
  localparam logic [SIN_W-1:0] SIN_TAB [QUARTER_DEG+1] = '{
    15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,  15'd1428,  15'd1713,
    15'd1997,  15'd2280,  15'd2563,  15'd2845,  15'd3126,  15'd3406,  15'd3686,
    15'd3964,  15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,  15'd5604,
    15'd5872,  15'd6138,  15'd6402,  15'd6664,  15'd6924,  15'd7182,  15'd7438,
    15'd7692,  15'd7943,  15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
    15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311, 15'd10531, 15'd10749,
    15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982, 15'd12176,
    15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255, 15'd13421,
    15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330, 15'd14466,
    15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
    15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826, 15'd15897,
    15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225, 15'd16262,
    15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382, 15'd16384
  };

  // table lookup, magnitudes past a quarter turn read as zero
  function automatic logic [SIN_W-1:0] sin_lookup(input logic [MAG_W-1:0] mag);
    if (mag > MAG_W'(QUARTER_DEG)) begin
      return '0;
    end else begin
      return SIN_TAB[mag];
    end
  endfunction

endpackage

// ===== rtl/hla_front.sv =====
// Front end of the Hough line accumulator: takes requests, sorts them into
// vote, read and clear commands and pushes them to the queue. Uses hla_pkg.
module hla_front #(
  parameter int NUM_THETA = hla_pkg::NUM_THETA_DEF,
  parameter int RHO_BINS  = hla_pkg::RHO_BINS_DEF,
  parameter int IMG_DIM   = hla_pkg::IMG_DIM_DEF
) (
  input  logic              in_valid_i,
  input  hla_pkg::in_item_t in_item_i,
  output logic              in_stall_o,
  input  logic              fifo_full_i,
  input  logic              clearing_i,
  output logic              push_o,
  output hla_pkg::cmd_t     cmd_o
);
  import hla_pkg::*;

  logic accept;
  logic keep;

  // hold off while the queue is full or the store is being swept
  assign in_stall_o = fifo_full_i || clearing_i;
  assign accept     = in_valid_i && !in_stall_o;

  // classify the request
  always_comb begin
    keep            = 1'b0;
    cmd_o.op        = CMD_VOTE;
    cmd_o.pix_x     = in_item_i.pix_x;
    cmd_o.pix_y     = in_item_i.pix_y;
    cmd_o.theta_sel = in_item_i.theta_sel;
    cmd_o.rho_sel   = in_item_i.rho_sel;
    cmd_o.rd_hit    = (int'(in_item_i.theta_sel) < NUM_THETA) &&
                      (int'(in_item_i.rho_sel) < RHO_BINS);
    unique case (in_item_i.mode)
      MODE_VOTE: begin
        // only edge pixels on the image cast votes
        keep     = (in_item_i.pixel_value == EDGE_VALUE) &&
                   (int'(in_item_i.pix_x) < IMG_DIM) &&
                   (int'(in_item_i.pix_y) < IMG_DIM);
        cmd_o.op = CMD_VOTE;
      end
      MODE_READ: begin
        keep     = 1'b1;
        cmd_o.op = CMD_READ;
      end
      MODE_CLEAR: begin
        keep     = 1'b1;
        cmd_o.op = CMD_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push_o = accept && keep;

endmodule

// ===== rtl/hla_fifo.sv =====
// Short command queue between the front end and the back end.
// Holds hla_pkg::cmd_t entries; uses hla_pkg.
module hla_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hla_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output hla_pkg::cmd_t data_o,
  output logic          empty_o
);
  import hla_pkg::*;

  cmd_t                  slot_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  // pointers wrap on their own since the depth is a power of two
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/hla_back.sv =====
// Back end of the Hough line accumulator: theta sweep, rho pipeline, vote
// store with read-modify-write, read path, clearing sweep and result register.
// Uses hla_pkg.
module hla_back #(
  parameter int NUM_THETA = hla_pkg::NUM_THETA_DEF,
  parameter int RHO_BINS  = hla_pkg::RHO_BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hla_pkg::cfg_t      cfg_i,
  input  logic               fifo_empty_i,
  input  hla_pkg::cmd_t      fifo_head_i,
  output logic               fifo_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output hla_pkg::out_item_t out_item_o,
  output hla_pkg::status_t   status_o
);
  import hla_pkg::*;

  localparam int TW       = $clog2(NUM_THETA);
  localparam int DEPTH    = NUM_THETA * RHO_BINS;
  localparam int AW       = $clog2(DEPTH);
  localparam int DEN      = NUM_THETA - 1;
  localparam int DEG_Q    = THETA_SPAN / DEN;
  localparam int DEG_R    = THETA_SPAN % DEN;
  localparam int REM_W    = $clog2(2 * DEN);
  localparam int REM_INIT = DEN / 2;
  localparam int FL_W     = SCALED_W - FRAC_BITS;
  localparam int IDX_W    = FL_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VOTE  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_RREAD = 3'd3;
  localparam logic [2:0] S_RDONE = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  // sequencer state
  logic [2:0]       state_q, state_d;
  logic [TW-1:0]    t_q, t_d;
  logic [DEG_W-1:0] deg_q, deg_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [AW-1:0]    base_q, base_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic             out_valid_q, out_valid_d;
  logic             issue;
  logic             pipe_busy;

  // angle stepping
  logic [REM_W:0]   rem_sum;
  logic             rem_carry;
  logic [REM_W-1:0] rem_step;
  logic [DEG_W-1:0] deg_step;

  // held command fields
  logic [PIX_W-1:0]   x_q, y_q;
  logic [AW-1:0]      rd_addr_q;
  logic               rd_hit_q;
  logic [THETA_W-1:0] rd_theta_q;
  logic [RSEL_W-1:0]  rd_rho_q;
  out_item_t          out_q;

  // rho pipeline
  logic             deg_hi;
  logic [MAG_W-1:0] mag;
  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q;
  logic [SIN_W-1:0] s1_sin_q, s1_cos_q;
  logic             s1_neg_q, s2_neg_q;
  logic [AW-1:0]    s1_base_q, s2_base_q, s3_base_q, s4_base_q;
  logic [PROD_W-1:0] s2_px_q, s2_py_q;
  logic signed [RHO_SUM_W-1:0] pxe, pye;
  logic signed [RHO_SUM_W-1:0] s3_rho_q;
  logic signed [INV_W:0]       inv_s;
  logic signed [SCALED_W-1:0]  s4_prod_q;
  logic [FL_W-1:0]             fl;
  logic signed [IDX_W-1:0]     idx5;
  logic                        hit5;
  logic [AW-1:0]               addr5;
  logic [AW-1:0]               s5_addr_q, s6_addr_q;

  // vote store
  logic [COUNT_W-1:0] store_mem [DEPTH];
  logic [COUNT_W-1:0] mem_rdata_q;
  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [COUNT_W-1:0] mem_wdata;

  // next angle: quotient and remainder of the span split over the bins
  always_comb begin
    rem_sum   = {1'b0, rem_q} + (REM_W+1)'(DEG_R);
    rem_carry = (rem_sum >= (REM_W+1)'(DEN));
    rem_step  = rem_carry ? REM_W'(rem_sum - (REM_W+1)'(DEN)) : REM_W'(rem_sum);
    deg_step  = deg_q + DEG_W'(DEG_Q) + DEG_W'(rem_carry);
  end

  assign pipe_busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q || s5_v_q || s6_v_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    deg_d       = deg_q;
    rem_d       = rem_q;
    base_d      = base_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    fifo_pop_o  = 1'b0;
    issue       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!fifo_empty_i) begin
          unique case (fifo_head_i.op)
            CMD_VOTE: begin
              fifo_pop_o = 1'b1;
              t_d        = '0;
              deg_d      = '0;
              rem_d      = REM_W'(REM_INIT);
              base_d     = '0;
              state_d    = S_VOTE;
            end
            CMD_READ: begin
              // wait until the result register is free
              if (!out_valid_q) begin
                fifo_pop_o = 1'b1;
                state_d    = S_RREAD;
              end
            end
            CMD_CLEAR: begin
              fifo_pop_o = 1'b1;
              clr_d      = '0;
              state_d    = S_CLEAR;
            end
            default: begin
              fifo_pop_o = 1'b1;
            end
          endcase
        end
      end
      S_VOTE: begin
        issue  = 1'b1;
        t_d    = t_q + 1'b1;
        deg_d  = deg_step;
        rem_d  = rem_step;
        base_d = base_q + AW'(RHO_BINS);
        if (t_q == TW'(NUM_THETA - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_d = S_IDLE;
        end
      end
      S_RREAD: begin
        state_d = S_RDONE;
      end
      S_RDONE: begin
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers, reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      t_q         <= '0;
      deg_q       <= '0;
      rem_q       <= '0;
      base_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      t_q         <= t_d;
      deg_q       <= deg_d;
      rem_q       <= rem_d;
      base_q      <= base_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      s1_v_q      <= issue;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= s3_v_q;
      s5_v_q      <= s4_v_q && hit5;
      s6_v_q      <= s5_v_q;
    end
  end

  // command fields latched at pop, read result captured in S_RDONE
  always_ff @(posedge clk_i) begin
    if (fifo_pop_o && (fifo_head_i.op == CMD_VOTE)) begin
      x_q <= fifo_head_i.pix_x;
      y_q <= fifo_head_i.pix_y;
    end
    if (fifo_pop_o && (fifo_head_i.op == CMD_READ)) begin
      rd_hit_q   <= fifo_head_i.rd_hit;
      rd_theta_q <= fifo_head_i.theta_sel;
      rd_rho_q   <= fifo_head_i.rho_sel;
      rd_addr_q  <= fifo_head_i.rd_hit ?
                    AW'(fifo_head_i.theta_sel) * AW'(RHO_BINS) + AW'(fifo_head_i.rho_sel) :
                    '0;
    end
    if (state_q == S_RDONE) begin
      out_q.bin_count <= rd_hit_q ? mem_rdata_q : '0;
      out_q.bin_theta <= rd_theta_q;
      out_q.bin_rho   <= rd_rho_q;
    end
  end

  // angle to table magnitude, sine sign follows the angle sign
  assign deg_hi = (deg_q >= DEG_W'(DEG_ZERO));
  assign mag    = deg_hi ? MAG_W'(deg_q - DEG_W'(DEG_ZERO)) :
                           MAG_W'(DEG_W'(DEG_ZERO) - deg_q);

  // rho datapath arithmetic
  assign pxe   = $signed({{(RHO_SUM_W-PROD_W){1'b0}}, s2_px_q});
  assign pye   = $signed({{(RHO_SUM_W-PROD_W){1'b0}}, s2_py_q});
  assign inv_s = $signed({1'b0, cfg_i.rho_step_inv});

  // floor of the Q22 value, then offset and range check
  assign fl    = s4_prod_q[SCALED_W-1:FRAC_BITS];
  assign idx5  = $signed({fl[FL_W-1], fl}) +
                 $signed({{(IDX_W-OFF_W){1'b0}}, cfg_i.rho_offset});
  assign hit5  = !idx5[IDX_W-1] && (idx5[IDX_W-2:0] < (IDX_W-1)'(RHO_BINS));
  assign addr5 = s4_base_q + AW'(idx5[IDX_W-2:0]);

  // rho pipeline stages
  always_ff @(posedge clk_i) begin
    s1_sin_q  <= sin_lookup(mag);
    s1_cos_q  <= sin_lookup(MAG_W'(QUARTER_DEG) - mag);
    s1_neg_q  <= !deg_hi;
    s1_base_q <= base_q;

    s2_px_q   <= PROD_W'(x_q) * PROD_W'(s1_cos_q);
    s2_py_q   <= PROD_W'(y_q) * PROD_W'(s1_sin_q);
    s2_neg_q  <= s1_neg_q;
    s2_base_q <= s1_base_q;

    s3_rho_q  <= s2_neg_q ? pxe - pye : pxe + pye;
    s3_base_q <= s2_base_q;

    s4_prod_q <= s3_rho_q * inv_s;
    s4_base_q <= s3_base_q;

    s5_addr_q <= addr5;
    s6_addr_q <= s5_addr_q;
  end

  // store ports: the vote read and the read request never overlap,
  // nor do the vote write and the clearing sweep
  assign mem_re    = s5_v_q || (state_q == S_RREAD);
  assign mem_raddr = (state_q == S_RREAD) ? rd_addr_q : s5_addr_q;
  assign mem_we    = s6_v_q || (state_q == S_CLEAR);
  assign mem_waddr = (state_q == S_CLEAR) ? clr_q : s6_addr_q;
  assign mem_wdata = (state_q == S_CLEAR)      ? '0 :
                     (mem_rdata_q == COUNT_MAX) ? mem_rdata_q :
                                                  mem_rdata_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= store_mem[mem_raddr];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;
  assign status_o.clearing = (state_q == S_CLEAR);

endmodule

// ===== rtl/hough_line_accumulator.sv =====
// Hough line accumulator top level: configuration registers, front end,
// command queue and back end. Uses hla_pkg, hla_front, hla_fifo, hla_back.
//
// Edge pixels vote into a (theta, rho) store of NUM_THETA * RHO_BINS 16-bit
// counters. A vote request occupies the back end until done: the store has
// one read and one write port, so the sweep does one read-modify-write per
// theta bin per cycle and then lets the six-stage rho pipeline drain before
// the next request. A read request passes through S_RREAD and S_RDONE, and
// its result waits in an output register; a clear request sweeps the store
// one counter per cycle over all NUM_THETA * RHO_BINS counters (368640 by
// default). The same sweep runs right after reset, and input stays stalled
// until it is done. A two-entry command queue keeps accepting requests while
// the back end works; non-edge pixels, pixels off the image and the unused
// mode are dropped at the front. Configuration writes are taken at any time
// and should be issued only while the block is idle.
module hough_line_accumulator #(
  parameter int NUM_THETA = hla_pkg::NUM_THETA_DEF,
  parameter int RHO_BINS  = hla_pkg::RHO_BINS_DEF,
  parameter int IMG_DIM   = hla_pkg::IMG_DIM_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  hla_pkg::in_item_t                  in_item_i,
  output logic                               in_stall_o,
  output logic                               out_valid_o,
  output hla_pkg::out_item_t                 out_item_o,
  input  logic                               out_stall_i,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [hla_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [hla_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import hla_pkg::*;

  cfg_t    cfg_q;
  status_t status;
  logic    fifo_push, fifo_full, fifo_pop, fifo_empty;
  cmd_t    fifo_in, fifo_head;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rho_offset   <= RHO_OFFSET_RST;
      cfg_q.rho_step_inv <= RHO_STEP_INV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_RHO_OFFSET: begin
          cfg_q.rho_offset <= cfg_data_i[OFF_W-1:0];
        end
        CFG_RHO_STEP_INV: begin
          cfg_q.rho_step_inv <= cfg_data_i[INV_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // request intake and classification
  hla_front #(
    .NUM_THETA (NUM_THETA),
    .RHO_BINS  (RHO_BINS),
    .IMG_DIM   (IMG_DIM)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .fifo_full_i (fifo_full),
    .clearing_i  (status.clearing),
    .push_o      (fifo_push),
    .cmd_o       (fifo_in)
  );

  // command queue
  hla_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_in),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (fifo_head),
    .empty_o (fifo_empty)
  );

  // voting, reading and clearing
  hla_back #(
    .NUM_THETA (NUM_THETA),
    .RHO_BINS  (RHO_BINS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_empty_i (fifo_empty),
    .fifo_head_i  (fifo_head),
    .fifo_pop_o   (fifo_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o),
    .status_o     (status)
  );

  // queue never written when full
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(fifo_push && fifo_full))
    else $error("command queue overflow");

  // queue never read when empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(fifo_pop && fifo_empty))
    else $error("command queue underflow");

  // out-of-range reads return a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((int'(out_item_o.bin_theta) >= NUM_THETA) ||
                    (int'(out_item_o.bin_rho) >= RHO_BINS))
    |-> (out_item_o.bin_count == '0))
    else $error("out-of-range read returned a nonzero count");

endmodule
